// ----- hdl/tx_ring_chunker_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the transmit ring chunker
// Concurrent checks sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TX_RING_CHUNKER_CORE_ASSERT_SVH
`define TX_RING_CHUNKER_CORE_ASSERT_SVH

// Same-cycle implication
`define TRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/trc_pkg.sv -----
// ----------------------------------------------------------------------------
// trc_pkg
// Shared codes and types of the transmit ring chunker.
// ----------------------------------------------------------------------------
`default_nettype none

package trc_pkg;

    typedef enum logic [1:0] {
        OP_PUSH       = 2'd0,
        OP_COMPLETE   = 2'd1,
        OP_CONNECT    = 2'd2,
        OP_DISCONNECT = 2'd3
    } trc_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } trc_state_t;

endpackage

`default_nettype wire

// ----- hdl/trc_if.sv -----
// ----------------------------------------------------------------------------
// trc_if
// Valid/ready channels of the transmit ring chunker: command words in,
// chunk bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface trc_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       end_of_block;
    logic       transfer_ok;

    modport source (output valid, opcode, data_byte, end_of_block, transfer_ok,
                    input ready);
    modport sink   (input valid, opcode, data_byte, end_of_block, transfer_ok,
                    output ready);
endinterface

interface trc_chunk_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       chunk_last;

    modport source (output valid, out_byte, chunk_last, input ready);
    modport sink   (input valid, out_byte, chunk_last, output ready);
endinterface

`default_nettype wire

// ----- hdl/trc_ring_mem.sv -----
// ----------------------------------------------------------------------------
// trc_ring_mem
// Byte ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trc_ring_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word while the consumer stalls
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tx_ring_chunker_core.sv -----
// ----------------------------------------------------------------------------
// tx_ring_chunker_core
// Transmit byte ring that hands queued data to a link in bounded chunks.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     word contents
//   cmd      in   valid/ready   opcode, data_byte, end_of_block, transfer_ok
//   chunk    out  valid/ready   out_byte, chunk_last
//
// A command word that starts no chunk leaves cmd ready again in the next cycle.
// A command word that starts a chunk of n bytes keeps cmd not ready until all
// n ring reads, one per byte, are issued; chunk stalls hold off those reads.
// The last byte may still sit in the output register when cmd is ready again.
// Reset clears the pointers, counts and link flag; ring contents are left
// undefined and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tx_ring_chunker_core
    import trc_pkg::*;
#(
    parameter int RING_DEPTH = 512,
    parameter int CHUNK_MAX  = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    trc_cmd_if.sink       cmd,
    trc_chunk_if.source   chunk
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int IW = $clog2(CHUNK_MAX + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(RING_DEPTH);
    localparam logic [SW-1:0] CMAX_S  = SW'(CHUNK_MAX);

    trc_state_t    state_reg, state_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] pend_reg, pend_next;
    logic [IW-1:0] infl_reg, infl_next;
    logic          active_reg, active_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [IW-1:0] remain_reg, remain_next;
    logic          out_valid_reg, out_valid_next;
    logic          last_reg, last_next;

    logic          cmd_fire;
    logic          wr_en;
    logic          rd_en;
    logic          start;
    logic [AW-1:0] head1;
    logic [CW-1:0] pend1;
    logic [SW-1:0] used;
    logic [SW-1:0] tail_sum;
    logic [AW-1:0] tail;
    logic [SW-1:0] hsum;
    logic [AW-1:0] head_adv;
    logic [SW-1:0] room;
    logic [SW-1:0] take_p;
    logic [SW-1:0] take_c;
    logic [IW-1:0] n;
    logic [7:0]    rd_data;

    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == ST_IDLE);

    // tail and full test from the current counts
    assign used     = SW'(pend_reg) + SW'(infl_reg);
    assign tail_sum = SW'(head_reg) + used;
    assign tail     = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
    assign hsum     = SW'(head_reg) + SW'(infl_reg);
    assign head_adv = (hsum >= DEPTH_S) ? AW'(hsum - DEPTH_S) : AW'(hsum);

    // chunk length: bounded by pending bytes, wrap point and chunk size
    assign room   = DEPTH_S - SW'(head1);
    assign take_p = (SW'(pend1) < room) ? SW'(pend1) : room;
    assign take_c = (take_p < CMAX_S) ? take_p : CMAX_S;
    assign n      = IW'(take_c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            pend_reg      <= '0;
            infl_reg      <= '0;
            active_reg    <= 1'b0;
            rd_ptr_reg    <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            pend_reg      <= pend_next;
            infl_reg      <= infl_next;
            active_reg    <= active_next;
            rd_ptr_reg    <= rd_ptr_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        pend_next   = pend_reg;
        infl_next   = infl_reg;
        active_next = active_reg;
        rd_ptr_next = rd_ptr_reg;
        remain_next = remain_reg;
        last_next   = last_reg;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        start       = 1'b0;
        head1       = head_reg;
        pend1       = pend_reg;

        out_valid_next = (out_valid_reg && !chunk.ready) ? 1'b1 : 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    case (trc_op_t'(cmd.opcode))
                        OP_PUSH:
                        begin
                            if (active_reg)
                            begin
                                // drop the byte when the ring is full
                                if (used < DEPTH_S)
                                begin
                                    wr_en = 1'b1;
                                    pend1 = pend_reg + CW'(1);
                                end
                                start = cmd.end_of_block && (infl_reg == '0);
                            end
                        end
                        OP_COMPLETE:
                        begin
                            if (cmd.transfer_ok)
                            begin
                                head1     = head_adv;
                                infl_next = '0;
                            end
                            start = (pend_reg != '0);
                        end
                        OP_CONNECT:
                        begin
                            infl_next   = '0;
                            start       = (pend_reg != '0);
                            active_next = 1'b1;
                        end
                        OP_DISCONNECT:
                        begin
                            active_next = 1'b0;
                        end
                        default:
                        begin
                            active_next = active_reg;
                        end
                    endcase

                    head_next = head1;
                    pend_next = pend1;

                    if (start)
                    begin
                        infl_next = n;
                        if (n != '0)
                        begin
                            pend_next   = pend1 - CW'(n);
                            rd_ptr_next = head1;
                            remain_next = n;
                            state_next  = ST_EMIT;
                        end
                    end
                end
            end
            ST_EMIT:
            begin
                // issue a read only when the output register is free next cycle
                if (remain_reg != '0 && (!out_valid_reg || chunk.ready))
                begin
                    rd_en          = 1'b1;
                    out_valid_next = 1'b1;
                    last_next      = (remain_reg == IW'(1));
                    rd_ptr_next    = rd_ptr_reg + AW'(1);
                    remain_next    = remain_reg - IW'(1);
                    if (remain_reg == IW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    trc_ring_mem #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail),
        .wr_data (cmd.data_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_ptr_reg),
        .rd_data (rd_data)
    );

    assign chunk.valid      = out_valid_reg;
    assign chunk.out_byte   = rd_data;
    assign chunk.chunk_last = last_reg;

endmodule

`default_nettype wire

// ----- hdl/trc_checker.sv -----
// ----------------------------------------------------------------------------
// trc_checker
// Port-level checks of the transmit ring chunker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tx_ring_chunker_core_assert.svh"

module trc_checker
    import trc_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic [1:0] cmd_opcode,
    input wire logic       chunk_valid,
    input wire logic       chunk_ready,
    input wire logic [7:0] chunk_out_byte,
    input wire logic       chunk_last
);

    // a stalled word keeps its place and contents
    `TRC_ASSERT_NXT(a_chunk_hold, chunk_valid && !chunk_ready,
        chunk_valid && $stable(chunk_out_byte) && $stable(chunk_last),
        "chunk word changed while stalled")

    // no command is taken while a chunk still has bytes to come
    `TRC_ASSERT_IMP(a_no_cmd_mid_chunk, chunk_valid && !chunk_last, !cmd_ready,
        "command accepted in the middle of a chunk")

    // a disconnect never starts a chunk
    `TRC_ASSERT_NXT(a_disc_no_chunk,
        cmd_valid && cmd_ready && (cmd_opcode == OP_DISCONNECT), cmd_ready,
        "disconnect blocked the command channel")

endmodule

bind tx_ring_chunker_core trc_checker u_trc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd.valid),
    .cmd_ready      (cmd.ready),
    .cmd_opcode     (cmd.opcode),
    .chunk_valid    (chunk.valid),
    .chunk_ready    (chunk.ready),
    .chunk_out_byte (chunk.out_byte),
    .chunk_last     (chunk.chunk_last)
);

`default_nettype wire

// ----- bench/tb_tx_ring_chunker_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tx_ring_chunker_core
// Self-checking bench for the transmit ring chunker. A directed table covers
// the link states, failed completions and resends. Four random phases follow,
// with sender gaps and receiver stalls varied between phases. Every chunk
// byte is checked against typed values in the directed rows, or else against a
// cycle-free model of the ring that is updated on each accepted command word.
// ----------------------------------------------------------------------------
module tb_tx_ring_chunker_core;
    import trc_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int RING_DEPTH  = 512;
    localparam int CHUNK_MAX   = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 40;
    localparam int BY_MODEL    = -1;
    localparam int NUM_ROWS    = 23;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } chunk_byte_t;

    typedef struct {
        trc_op_t    op;
        logic [7:0] data;
        logic       eob;
        logic       ok;
        int         typed_n;
        logic [7:0] typed_byte;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    trc_cmd_if   cmd_bus ();
    trc_chunk_if chunk_bus ();

    tx_ring_chunker_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .chunk (chunk_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ring model
    logic [7:0] tx_mem [RING_DEPTH];
    logic [8:0] rd_ptr;
    logic [9:0] queued_cnt;
    logic [5:0] sent_cnt;
    logic       link_up;

    chunk_byte_t fresh_bytes [$];
    chunk_byte_t awaited_bytes [$];
    chunk_byte_t got_want;

    int idle_pct;
    int stall_pct;
    int cmd_words;
    int error_count;
    int cycle_cnt;

    // typed rows: count and byte read straight off the ring behaviour
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{OP_PUSH,       8'hFF, 1'b1, 1'b0, 0,        8'h00},  // inactive: dropped
        '{OP_DISCONNECT, 8'h00, 1'b0, 1'b0, 0,        8'h00},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b1, 0,        8'h00},  // nothing in flight
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b0, 0,        8'h00},
        '{OP_CONNECT,    8'h00, 1'b0, 1'b0, 0,        8'h00},  // nothing pending
        '{OP_PUSH,       8'h00, 1'b1, 1'b1, 1,        8'h00},
        '{OP_PUSH,       8'hA5, 1'b1, 1'b0, 0,        8'h00},  // chunk busy: queue only
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b1, 1,        8'hA5},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b0, 0,        8'h00},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b1, 0,        8'h00},
        '{OP_PUSH,       8'h5A, 1'b0, 1'b0, 0,        8'h00},
        '{OP_PUSH,       8'hC3, 1'b0, 1'b1, 0,        8'h00},
        '{OP_PUSH,       8'h3C, 1'b1, 1'b0, BY_MODEL, 8'h00},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b0, 0,        8'h00},
        '{OP_PUSH,       8'h11, 1'b1, 1'b0, 0,        8'h00},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b0, 1,        8'h5A},  // failed: resend from head
        '{OP_PUSH,       8'h22, 1'b0, 1'b0, 0,        8'h00},
        '{OP_DISCONNECT, 8'hFF, 1'b1, 1'b1, 0,        8'h00},
        '{OP_PUSH,       8'h77, 1'b1, 1'b0, 0,        8'h00},
        '{OP_CONNECT,    8'h00, 1'b0, 1'b0, 1,        8'h5A},  // flight cleared, resend
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b1, 0,        8'h00},
        '{OP_PUSH,       8'hFF, 1'b1, 1'b0, 1,        8'hFF},
        '{OP_COMPLETE,   8'h00, 1'b0, 1'b1, 0,        8'h00}
    };

    function automatic void start_chunk();
        int n;
        int room;
        int k;
        n    = int'(queued_cnt);
        room = RING_DEPTH - int'(rd_ptr);
        if (room < n)
            n = room;
        if (n == 0)
        begin
            sent_cnt = '0;
            return;
        end
        if (n > CHUNK_MAX)
            n = CHUNK_MAX;
        sent_cnt   = 6'(n);
        queued_cnt = queued_cnt - 10'(n);
        for (k = 0; k < n; k++)
            fresh_bytes.push_back('{tx_mem[(int'(rd_ptr) + k) % RING_DEPTH], k == n - 1});
    endfunction

    function automatic void predict_word(trc_op_t op, logic [7:0] data, logic eob, logic ok);
        int wr_ptr;
        case (op)
            OP_PUSH:
            begin
                if (link_up)
                begin
                    if (int'(queued_cnt) + int'(sent_cnt) < RING_DEPTH)
                    begin
                        wr_ptr = (int'(rd_ptr) + int'(queued_cnt) + int'(sent_cnt)) % RING_DEPTH;
                        tx_mem[wr_ptr] = data;
                        queued_cnt++;
                    end
                    // a dropped byte may still close the block
                    if (eob && sent_cnt == 0)
                        start_chunk();
                end
            end
            OP_COMPLETE:
            begin
                if (ok)
                begin
                    rd_ptr   = 9'((int'(rd_ptr) + int'(sent_cnt)) % RING_DEPTH);
                    sent_cnt = '0;
                end
                if (queued_cnt != 0)
                    start_chunk();
            end
            OP_CONNECT:
            begin
                sent_cnt = '0;
                if (queued_cnt != 0)
                    start_chunk();
                link_up = 1'b1;
            end
            default:
                link_up = 1'b0;
        endcase
    endfunction

    task automatic send_word(input trc_op_t op, input logic [7:0] data, input logic eob,
                             input logic ok, input int typed_n, input logic [7:0] typed_byte);
        while ($urandom_range(99) < idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.opcode       <= op;
        cmd_bus.data_byte    <= data;
        cmd_bus.end_of_block <= eob;
        cmd_bus.transfer_ok  <= ok;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        fresh_bytes.delete();
        predict_word(op, data, eob, ok);
        if (typed_n == BY_MODEL)
        begin
            foreach (fresh_bytes[i])
                awaited_bytes.push_back(fresh_bytes[i]);
        end
        else if (typed_n == 1)
            awaited_bytes.push_back('{typed_byte, 1'b1});
        cmd_words++;
    endtask

    task automatic send_cmd(input trc_op_t op, input logic [7:0] data, input logic eob,
                            input logic ok);
        send_word(op, data, eob, ok, BY_MODEL, 8'h00);
    endtask

    // hold the command side until every predicted byte is out
    task automatic settle();
        cmd_bus.valid <= 1'b0;
        while (awaited_bytes.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n_words);
        int stop;
        int len;
        int k;
        int pick;
        idle_pct  = idle;
        stall_pct = stall;
        stop      = cmd_words + n_words;
        while (cmd_words < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
            begin
                // well-formed send call: bytes, end of block, then mostly a completion
                if (!link_up)
                    send_cmd(OP_CONNECT, 8'($urandom), 1'($urandom), 1'($urandom));
                len = ($urandom_range(9) == 0) ? $urandom_range(33, 80) : $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    send_cmd(OP_PUSH, 8'($urandom),
                             (k == len - 1) || ($urandom_range(15) == 0), 1'($urandom));
                if ($urandom_range(4) != 0)
                    send_cmd(OP_COMPLETE, 8'($urandom), 1'($urandom), $urandom_range(5) != 0);
            end
            else if (pick < 80)
                send_cmd(OP_COMPLETE, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (pick < 88)
            begin
                send_cmd(OP_DISCONNECT, 8'($urandom), 1'($urandom), 1'($urandom));
                len = $urandom_range(0, 3);
                for (k = 0; k < len; k++)
                    send_cmd(OP_PUSH, 8'($urandom), 1'($urandom), 1'($urandom));
                send_cmd(OP_CONNECT, 8'($urandom), 1'($urandom), 1'($urandom));
            end
            else
                send_cmd(trc_op_t'($urandom_range(3)), 8'($urandom), 1'($urandom),
                         1'($urandom));
        end
    endtask

    always @(posedge clk)
        chunk_bus.ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && chunk_bus.valid && chunk_bus.ready)
        begin
            if (awaited_bytes.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected chunk word: expected none, got byte %02h last %0b",
                         $time, chunk_bus.out_byte, chunk_bus.chunk_last);
            end
            else
            begin
                got_want = awaited_bytes.pop_front();
                if (chunk_bus.out_byte !== got_want.value)
                begin
                    error_count++;
                    $display("%0t: out_byte mismatch: expected %02h, got %02h",
                             $time, got_want.value, chunk_bus.out_byte);
                end
                if (chunk_bus.chunk_last !== got_want.last)
                begin
                    error_count++;
                    $display("%0t: chunk_last mismatch: expected %0b, got %0b",
                             $time, got_want.last, chunk_bus.chunk_last);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int r;
        cmd_bus.valid        = 1'b0;
        cmd_bus.opcode       = OP_PUSH;
        cmd_bus.data_byte    = 8'h00;
        cmd_bus.end_of_block = 1'b0;
        cmd_bus.transfer_ok  = 1'b0;
        chunk_bus.ready      = 1'b0;
        rst_n                = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        cmd_words            = 0;
        error_count          = 0;
        cycle_cnt            = 0;
        foreach (tx_mem[i])
            tx_mem[i] = 8'h00;
        rd_ptr     = '0;
        queued_cnt = '0;
        sent_cnt   = '0;
        link_up    = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < NUM_ROWS; r++)
            send_word(directed_rows[r].op, directed_rows[r].data, directed_rows[r].eob,
                      directed_rows[r].ok, directed_rows[r].typed_n,
                      directed_rows[r].typed_byte);
        settle();

        run_phase(0, 0, 103);
        settle();
        run_phase(47, 0, 103);
        settle();
        run_phase(0, 47, 103);
        settle();
        run_phase(12, 12, 103);
        settle();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
